[hdl/bpc_pkg.sv]
// Shared types, constants and helpers for the barometric compensation block.
// Used by bpc_mul and baro_temp_press_compensation; no dependencies.
package bpc_pkg;

   typedef logic [63:0] word_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_CAL_TEMP    = 2'd0,
      CSR_CAL_PRESS_A = 2'd1,
      CSR_CAL_PRESS_B = 2'd2
   } csr_index_type;

   localparam int unsigned NUM_STAGES = 25;

   // exact reciprocals for 32-bit unsigned operands
   localparam logic [31:0] RECIP_DIV10  = 32'hCCCC_CCCD;  // shift 35
   localparam logic [31:0] RECIP_DIV100 = 32'h51EB_851F;  // shift 37

   function automatic word_type sext8(input logic [7:0] x);
      return {{56{x[7]}}, x};
   endfunction

   function automatic word_type sext16(input logic [15:0] x);
      return {{48{x[15]}}, x};
   endfunction

   // signed divide by 2**sh, truncating toward zero, 64-bit wrap
   function automatic word_type sdiv_p2(input word_type x, input int unsigned sh);
      word_type mag;
      word_type q;
      mag = x[63] ? (64'd0 - x) : x;
      q   = mag >> sh;
      return x[63] ? (64'd0 - q) : q;
   endfunction

endpackage

[hdl/baro_temp_press_compensation.sv]
// Top level: calibration registers, 25-stage compensation pipeline, output skid.
// Depends on bpc_pkg and bpc_mul.
//
// Usage:
//   req_ channel carries one raw pressure / temperature pair per request.
//   rsp_ channel returns temperature in 0.01 degC and pressure in Pa.
//   csr_ port writes the three calibration words; write only while idle.
// Throughput: one request per cycle while the skid buffer is empty; every
//   stage advances together and the wide products run through registered
//   32x32 partial-product multipliers.
// Reset: clears all stage valid bits, the skid buffer and calibration words.
// Stall: when rsp_tready is low the finished result moves into a one-entry
//   skid buffer and the pipeline still advances that cycle; while the skid
//   holds a result the pipeline freezes and req_tready is low. Nothing is
//   lost or repeated, and results leave in request order.
module baro_temp_press_compensation
   import bpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // raw_pressure[23:0], raw_temperature[47:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // temperature_centi[15:0], pressure_pascal[33:16]
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [63:0] csr_wdata
);

   logic [39:0] cal_temp_ff;
   word_type    cal_pa_ff;
   word_type    cal_pb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff <= '0;
         cal_pa_ff   <= '0;
         cal_pb_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_CAL_TEMP:    cal_temp_ff <= csr_wdata[39:0];
            CSR_CAL_PRESS_A: cal_pa_ff   <= csr_wdata;
            CSR_CAL_PRESS_B: cal_pb_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // calibration fields, extended to 64 bits
   word_type t1_w, t2_w, t3_w, p1m_w, p2m_w, p3_w, p4_w, p5_w;
   word_type p6_w, p7_w, p8_w, p9_w, p10_w, p11_w;

   assign t1_w  = 64'(cal_temp_ff[15:0]);
   assign t2_w  = 64'(cal_temp_ff[31:16]);
   assign t3_w  = sext8(cal_temp_ff[39:32]);
   assign p1m_w = sext16(cal_pa_ff[15:0]) - 64'd16384;
   assign p2m_w = sext16(cal_pa_ff[31:16]) - 64'd16384;
   assign p3_w  = sext8(cal_pa_ff[39:32]);
   assign p4_w  = sext8(cal_pa_ff[47:40]);
   assign p5_w  = 64'(cal_pa_ff[63:48]);
   assign p6_w  = 64'(cal_pb_ff[15:0]);
   assign p7_w  = sext8(cal_pb_ff[23:16]);
   assign p8_w  = sext8(cal_pb_ff[31:24]);
   assign p9_w  = sext16(cal_pb_ff[47:32]);
   assign p10_w = sext8(cal_pb_ff[55:48]);
   assign p11_w = sext8(cal_pb_ff[63:56]);

   // handshake: whole pipeline advances unless the skid holds a result
   logic        en;
   logic        skid_vld_ff;
   logic [33:0] skid_data_ff;
   logic [NUM_STAGES:1] vld_ff;

   assign en         = !skid_vld_ff;
   assign req_tready = en;

   word_type up_in;
   word_type ut_in;
   assign up_in = 64'(req_tdata[23:0]);
   assign ut_in = 64'(req_tdata[47:24]);

   // carried operands
   word_type up_ff [1:18];
   word_type tl_ff [7:10];
   logic [15:0] temp_ff [10:25];
   word_type cp_ff [8:21];
   word_type ofq_ff [13:16];
   word_type snq_ff [13:16];
   word_type os_ff [18:20];

   word_type at1_ff, b4_ff, b5_ff, e6_ff, tx8_ff, tq9_ff, bp5_ff;
   word_type bb10_ff, cq10_ff, f10_ff, f11_ff, es10_ff, es11_ff;
   word_type ofp12_ff, snp12_ff, cc13_ff, dd13_ff;
   word_type do16_ff, bs16_ff, off17_ff, sens17_ff, sa18_ff;
   word_type q18_ff, s21_ff, e21_ff, e22_ff, s22_ff, sum23_ff;
   logic [50:0] mag14_ff;
   logic        neg14_ff, neg15_ff, neg16_ff, neg17_ff;
   logic [23:0] mlo15_ff, mlo16_ff;
   logic [26:0] mhi15_ff;
   logic [26:0] qh16_ff, qh17_ff;
   logic [3:0]  rh16_ff;
   logic [23:0] ql17_ff;
   logic [23:0] v24_ff;
   logic        neg24_ff;
   logic [17:0] pres25_ff;

   // multiplier outputs
   word_type uu2, b3, c3, pf4, d5, bu7, aa9, f9, es9, pb9;
   word_type eo11, ds11, bt12, cu12, po15, ps15, uq20, a20;

   bpc_mul u_mul_uu (.clock, .en, .op_a(up_in),     .op_b(up_in),     .prod(uu2));
   bpc_mul u_mul_b  (.clock, .en, .op_a(t2_w),      .op_b(at1_ff),    .prod(b3));
   bpc_mul u_mul_c  (.clock, .en, .op_a(at1_ff),    .op_b(at1_ff),    .prod(c3));
   bpc_mul u_mul_pf (.clock, .en, .op_a(p11_w),     .op_b(uu2),       .prod(pf4));
   bpc_mul u_mul_d  (.clock, .en, .op_a(c3),        .op_b(t3_w),      .prod(d5));
   bpc_mul u_mul_bu (.clock, .en, .op_a(bp5_ff),    .op_b(up_ff[5]),  .prod(bu7));
   bpc_mul u_mul_aa (.clock, .en, .op_a(tl_ff[7]),  .op_b(tl_ff[7]),  .prod(aa9));
   bpc_mul u_mul_f  (.clock, .en, .op_a(p6_w),      .op_b(tl_ff[7]),  .prod(f9));
   bpc_mul u_mul_es (.clock, .en, .op_a(p2m_w),     .op_b(tl_ff[7]),  .prod(es9));
   bpc_mul u_mul_pb (.clock, .en, .op_a(p10_w),     .op_b(tl_ff[7]),  .prod(pb9));
   bpc_mul u_mul_eo (.clock, .en, .op_a(p7_w),      .op_b(aa9),       .prod(eo11));
   bpc_mul u_mul_ds (.clock, .en, .op_a(p3_w),      .op_b(aa9),       .prod(ds11));
   bpc_mul u_mul_bt (.clock, .en, .op_a(bb10_ff),   .op_b(tl_ff[10]), .prod(bt12));
   bpc_mul u_mul_cu (.clock, .en, .op_a(cq10_ff),   .op_b(up_ff[10]), .prod(cu12));
   bpc_mul u_mul_po (.clock, .en, .op_a(p8_w),      .op_b(cc13_ff),   .prod(po15));
   bpc_mul u_mul_ps (.clock, .en, .op_a(p4_w),      .op_b(cc13_ff),   .prod(ps15));
   bpc_mul u_mul_uq (.clock, .en, .op_a(up_ff[18]), .op_b(q18_ff),    .prod(uq20));
   bpc_mul u_mul_a  (.clock, .en, .op_a(sa18_ff),   .op_b(up_ff[18]), .prod(a20));

   logic [58:0] qh_prod;
   logic [59:0] ql_prod;
   logic [55:0] pres_prod;
   word_type    tq_w;
   word_type    sum25_w;
   word_type    qmag_w;

   assign qh_prod   = 59'(mhi15_ff) * 59'(RECIP_DIV10);
   assign ql_prod   = 60'({rh16_ff, mlo16_ff}) * 60'(RECIP_DIV10);
   assign pres_prod = 56'(v24_ff) * 56'(RECIP_DIV100);
   assign tq_w      = tq9_ff;
   assign sum25_w   = (sum23_ff << 4) + (sum23_ff << 3) + sum23_ff;
   assign qmag_w    = {13'd0, qh17_ff, 24'd0} + 64'(ql17_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         up_ff[1] <= up_in;
         for (int i = 2; i <= 18; i++) up_ff[i] <= up_ff[i-1];

         // temperature polynomial
         at1_ff <= ut_in - (t1_w << 8);
         b4_ff  <= b3;
         b5_ff  <= b4_ff;
         e6_ff  <= (b5_ff << 18) + d5;
         tl_ff[7] <= sdiv_p2(e6_ff, 32);
         for (int i = 8; i <= 10; i++) tl_ff[i] <= tl_ff[i-1];
         tx8_ff <= (tl_ff[7] << 4) + (tl_ff[7] << 3) + tl_ff[7];
         tq9_ff <= sdiv_p2(tx8_ff, 14);
         if ($signed(tq_w) < -64'sd32768)
            temp_ff[10] <= 16'h8000;
         else if ($signed(tq_w) > 64'sd32767)
            temp_ff[10] <= 16'h7FFF;
         else
            temp_ff[10] <= tq_w[15:0];
         for (int i = 11; i <= 25; i++) temp_ff[i] <= temp_ff[i-1];

         // up-only cubic term
         bp5_ff <= sdiv_p2(pf4, 16);
         cp_ff[8] <= sdiv_p2(bu7, 7);
         for (int i = 9; i <= 21; i++) cp_ff[i] <= cp_ff[i-1];

         // offset / sensitivity terms
         bb10_ff  <= sdiv_p2(aa9, 6);
         cq10_ff  <= pb9 + (p9_w << 16);
         f10_ff   <= f9;
         f11_ff   <= f10_ff;
         es10_ff  <= es9;
         es11_ff  <= es10_ff;
         ofp12_ff <= (eo11 << 4) + (f11_ff << 22);
         snp12_ff <= (ds11 << 2) + (es11_ff << 21);
         ofq_ff[13] <= ofp12_ff + (p5_w << 47);
         snq_ff[13] <= snp12_ff + (p1m_w << 46);
         for (int i = 14; i <= 16; i++) begin
            ofq_ff[i] <= ofq_ff[i-1];
            snq_ff[i] <= snq_ff[i-1];
         end
         cc13_ff   <= sdiv_p2(bt12, 8);
         dd13_ff   <= sdiv_p2(cu12, 13);
         do16_ff   <= sdiv_p2(po15, 5);
         bs16_ff   <= sdiv_p2(ps15, 5);
         off17_ff  <= ofq_ff[16] + do16_ff;
         sens17_ff <= snq_ff[16] + bs16_ff;
         sa18_ff   <= sdiv_p2(sens17_ff, 24);
         os_ff[18] <= sdiv_p2(off17_ff, 2);
         os_ff[19] <= os_ff[18];
         os_ff[20] <= os_ff[19];

         // signed divide by 10: 51-bit magnitude split into a 27-bit and a 24-bit digit
         mag14_ff <= dd13_ff[63] ? 51'(64'd0 - dd13_ff) : dd13_ff[50:0];
         neg14_ff <= dd13_ff[63];
         mhi15_ff <= mag14_ff[50:24];
         mlo15_ff <= mag14_ff[23:0];
         neg15_ff <= neg14_ff;
         rh16_ff  <= 4'(mhi15_ff - 27'(qh_prod >> 35) * 27'd10);
         qh16_ff  <= 27'(qh_prod >> 35);
         mlo16_ff <= mlo15_ff;
         neg16_ff <= neg15_ff;
         ql17_ff  <= 24'(ql_prod >> 35);
         qh17_ff  <= qh16_ff;
         neg17_ff <= neg16_ff;
         q18_ff   <= neg17_ff ? (64'd0 - qmag_w) : qmag_w;

         // final sum
         e21_ff   <= sdiv_p2(uq20, 9);
         s21_ff   <= os_ff[20] + a20;
         e22_ff   <= (e21_ff << 3) + (e21_ff << 1);
         s22_ff   <= s21_ff + cp_ff[21];
         sum23_ff <= s22_ff + e22_ff;
         v24_ff   <= sum25_w[63:40];
         neg24_ff <= sum23_ff[63];
         pres25_ff <= neg24_ff ? 18'd0 : 18'(pres_prod >> 37);
      end
   end

   // valid bits and skid buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (en) vld_ff <= {vld_ff[NUM_STAGES-1:1], req_tvalid};
         if (skid_vld_ff && rsp_tready)
            skid_vld_ff <= 1'b0;
         else if (en && vld_ff[NUM_STAGES] && !rsp_tready)
            skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en && vld_ff[NUM_STAGES] && !rsp_tready)
         skid_data_ff <= {pres25_ff, temp_ff[25]};
   end

   assign rsp_tvalid = skid_vld_ff | vld_ff[NUM_STAGES];
   assign rsp_tdata  = {6'd0, skid_vld_ff ? skid_data_ff : {pres25_ff, temp_ff[25]}};

endmodule

[hdl/bpc_mul.sv]
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
// Built from 32x32 partial products; depends on bpc_pkg.
module bpc_mul
   import bpc_pkg::*;
(
   input  logic     clock,
   input  logic     en,
   input  word_type op_a,
   input  word_type op_b,
   output word_type prod
);

   word_type    ll_ff;
   logic [31:0] lh_ff;
   logic [31:0] hl_ff;
   word_type    prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff   <= 64'(op_a[31:0]) * 64'(op_b[31:0]);
         lh_ff   <= op_a[31:0] * op_b[63:32];
         hl_ff   <= op_a[63:32] * op_b[31:0];
         // cross terms only reach the upper word
         prod_ff <= ll_ff + {lh_ff + hl_ff, 32'd0};
      end
   end

   assign prod = prod_ff;

endmodule
